// File: sv/smq_pkg.sv
// Shared types, codes and helpers for the stepper move queue.
`timescale 1ns / 1ps
`default_nettype none

package smq_pkg;

	// Default number of slots; one slot always stays free.
	localparam int DEFAULT_QUEUE_DEPTH = 32;

	localparam int STEP_W = 31;
	localparam int DUR_W  = 32;
	localparam int DIR_W  = 3;
	localparam int FILL_W = 5;

	// Command codes.
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// One stored move.
	typedef struct packed {
		logic [STEP_W-1:0] abs_x;
		logic [STEP_W-1:0] abs_y;
		logic [STEP_W-1:0] abs_z;
		logic [STEP_W-1:0] major;
		logic [DUR_W-1:0]  period;
		logic [DIR_W-1:0]  dirs;
	} move_entry_t;

	// Absolute value of a signed count, saturated to 31 bits.
	function automatic logic [STEP_W-1:0] abs_sat(input logic signed [31:0] v);
		logic [31:0] a;
		a = v[31] ? (32'd0 - 32'(v)) : 32'(v);
		return a[31] ? {STEP_W{1'b1}} : a[STEP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/smq_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module smq_divider
	import smq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DUR_W-1:0]  dividend,
	input  wire logic [STEP_W-1:0] divisor,
	output logic                   done,
	output logic [DUR_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(DUR_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DUR_W-1:0]  rem_q;
	logic [DUR_W-1:0]  dvd_q;
	logic [STEP_W-1:0] dvs_q;

	logic [DUR_W-1:0] rem_shift;
	logic [DUR_W:0]   diff;

	// Shift in the next dividend bit and try to subtract the divisor.
	always_comb begin
		rem_shift = {rem_q[DUR_W-2:0], dvd_q[DUR_W-1]};
		diff      = {1'b0, rem_shift} - {{(DUR_W + 1 - STEP_W){1'b0}}, dvs_q};
	end

	// Control: counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DUR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift into the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DUR_W]) begin
				rem_q <= diff[DUR_W-1:0];
			end else begin
				rem_q <= rem_shift;
			end
			dvd_q <= {dvd_q[DUR_W-2:0], ~diff[DUR_W]};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// File: sv/stepper_move_queue.sv
// Top level of the stepper move queue: command sequencer, move store and result register.
// A push passes through S_MAX, S_DIVIDE and S_FINISH; the one-bit-per-cycle divider that
// forms the step period runs in S_DIVIDE. A zero-length push passes through S_MAX and S_FINISH,
// a pop through S_POP_RD and S_FINISH; a flush, a rejected push or pop, or an unused command
// goes straight to S_FINISH. One command is worked on at a time; the next is accepted the
// cycle after the result is registered, and a stalled result holds the sequencer.
// Reset empties the queue and clears all control state; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stepper_move_queue
	import smq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] move_x,
	input  wire logic signed [31:0] move_y,
	input  wire logic signed [31:0] move_z,
	input  wire logic [DUR_W-1:0]   duration_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [STEP_W-1:0]       abs_x,
	output logic [STEP_W-1:0]       abs_y,
	output logic [STEP_W-1:0]       abs_z,
	output logic [STEP_W-1:0]       major_steps,
	output logic [DUR_W-1:0]        step_period,
	output logic [DIR_W-1:0]        dir_bits,
	output logic [FILL_W-1:0]       fill_level
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAX,
		S_DIVIDE,
		S_POP_RD,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;

	// Operands of the command in progress.
	logic [STEP_W-1:0] ax_q;
	logic [STEP_W-1:0] ay_q;
	logic [STEP_W-1:0] az_q;
	logic [STEP_W-1:0] maj_q;
	logic [DIR_W-1:0]  dir_q;
	logic [DUR_W-1:0]  dur_q;
	logic [1:0]        op_status_q;
	logic              op_pop_q;

	// Result register.
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [STEP_W-1:0] abs_x_q;
	logic [STEP_W-1:0] abs_y_q;
	logic [STEP_W-1:0] abs_z_q;
	logic [STEP_W-1:0] major_q;
	logic [DUR_W-1:0]  period_q;
	logic [DIR_W-1:0]  dirs_q;
	logic [FILL_W-1:0] fill_q;

	// Move store.
	move_entry_t mem [QUEUE_DEPTH];
	move_entry_t rdata_q;
	move_entry_t wr_entry;
	logic        mem_we;

	logic             in_take;
	logic [PTR_W-1:0] wp_next;
	logic [PTR_W-1:0] rp_next;
	logic [CNT_W-1:0] held;
	logic [STEP_W-1:0] max_xy;
	logic [STEP_W-1:0] max_xyz;
	logic             div_start;
	logic             div_done;
	logic [DUR_W-1:0] div_quot;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && (state_q == S_IDLE);

	// Pointer arithmetic and fill count.
	always_comb begin
		wp_next = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		rp_next = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
		held    = {1'b0, wp_q} - {1'b0, rp_q}
			+ ((wp_q < rp_q) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(0));
	end

	// Largest axis count.
	always_comb begin
		max_xy  = (ay_q > ax_q) ? ay_q : ax_q;
		max_xyz = (az_q > max_xy) ? az_q : max_xy;
	end

	assign div_start = (state_q == S_MAX) && (max_xyz != '0);
	assign mem_we    = (state_q == S_DIVIDE) && div_done;

	always_comb begin
		wr_entry.abs_x  = ax_q;
		wr_entry.abs_y  = ay_q;
		wr_entry.abs_z  = az_q;
		wr_entry.major  = maj_q;
		wr_entry.period = div_quot;
		wr_entry.dirs   = dir_q;
	end

	smq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dur_q),
		.divisor  (max_xyz),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Store write, and a registered read at the read pointer that is held until the result leaves.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= wr_entry;
		end
		if (state_q == S_POP_RD) begin
			rdata_q <= mem[rp_q];
		end
	end

	// Operand capture; these registers need no reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			ax_q  <= abs_sat(move_x);
			ay_q  <= abs_sat(move_y);
			az_q  <= abs_sat(move_z);
			dir_q <= {move_z[31], move_y[31], move_x[31]};
			dur_q <= duration_us;
		end
		if (state_q == S_MAX) begin
			maj_q <= max_xyz;
		end
	end

	// Sequencer, pointers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			op_status_q <= ST_OK;
			op_pop_q    <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			abs_x_q     <= '0;
			abs_y_q     <= '0;
			abs_z_q     <= '0;
			major_q     <= '0;
			period_q    <= '0;
			dirs_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						op_status_q <= ST_OK;
						op_pop_q    <= 1'b0;
						case (cmd)
							CMD_PUSH: begin
								if (wp_next == rp_q) begin
									op_status_q <= ST_FULL;
									state_q     <= S_FINISH;
								end else begin
									state_q <= S_MAX;
								end
							end
							CMD_POP: begin
								if (rp_q == wp_q) begin
									op_status_q <= ST_EMPTY;
									state_q     <= S_FINISH;
								end else begin
									op_pop_q <= 1'b1;
									state_q  <= S_POP_RD;
								end
							end
							CMD_FLUSH: begin
								rp_q    <= wp_q;
								state_q <= S_FINISH;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_MAX: begin
					if (max_xyz == '0) begin
						op_status_q <= ST_ZERO;
						state_q     <= S_FINISH;
					end else begin
						state_q <= S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					if (div_done) begin
						wp_q    <= wp_next;
						state_q <= S_FINISH;
					end
				end
				S_POP_RD: begin
					rp_q    <= rp_next;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= op_status_q;
						abs_x_q     <= op_pop_q ? rdata_q.abs_x : '0;
						abs_y_q     <= op_pop_q ? rdata_q.abs_y : '0;
						abs_z_q     <= op_pop_q ? rdata_q.abs_z : '0;
						major_q     <= op_pop_q ? rdata_q.major : '0;
						period_q    <= op_pop_q ? rdata_q.period : '0;
						dirs_q      <= op_pop_q ? rdata_q.dirs : '0;
						fill_q      <= FILL_W'(held);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign abs_x       = abs_x_q;
	assign abs_y       = abs_y_q;
	assign abs_z       = abs_z_q;
	assign major_steps = major_q;
	assign step_period = period_q;
	assign dir_bits    = dirs_q;
	assign fill_level  = fill_q;

	// The queue never holds more than one less than its slot count.
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held < CNT_W'(QUEUE_DEPTH))
		else $error("queue holds too many moves");

	// The divider only finishes while the sequencer waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVIDE)
		else $error("divider finished outside a push");

	// A store write never lands on the slot at the read pointer's predecessor.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> wp_next != rp_q)
		else $error("store write into a full queue");

	// A new result appears only out of the finishing state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside the finishing state");

endmodule

`default_nettype wire
